// ----- sv/kuf_pkg.sv -----
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared types and constants for the union-find edge filter: node and rank
// word types, the rank ceiling and the command code.
// ----------------------------------------------------------------------------
`default_nettype none

package kuf_pkg;

	// widths fixed by the edge word
	localparam int NODE_W = 10;
	localparam int RANK_W = 4;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [RANK_W-1:0] rank_t;

	// rank saturates here
	localparam rank_t RANK_MAX = rank_t'((1 << RANK_W) - 1);

	// command codes
	localparam logic CMD_EDGE  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

endpackage

`default_nettype wire

// ----- sv/kuf_forest_mem.sv -----
// ----------------------------------------------------------------------------
// kuf_forest_mem
// Parent and rank tables of the disjoint-set forest. One shared read address
// with registered read data, and one write port per table.
// ----------------------------------------------------------------------------
`default_nettype none

module kuf_forest_mem #(
	parameter int DEPTH = 1024,
	parameter int IDX_W = 10
) (
	input  wire                  clk,
	input  wire  [IDX_W-1:0]     rd_addr,
	output logic [IDX_W-1:0]     rd_parent,
	output kuf_pkg::rank_t       rd_rank,
	input  wire                  parent_we,
	input  wire  [IDX_W-1:0]     parent_waddr,
	input  wire  [IDX_W-1:0]     parent_wdata,
	input  wire                  rank_we,
	input  wire  [IDX_W-1:0]     rank_waddr,
	input  kuf_pkg::rank_t       rank_wdata
);

	logic [IDX_W-1:0] parent_mem [DEPTH];
	kuf_pkg::rank_t   rank_mem   [DEPTH];

	// parent table
	always_ff @(posedge clk) begin
		if (parent_we) begin
			parent_mem[parent_waddr] <= parent_wdata;
		end
		rd_parent <= parent_mem[rd_addr];
	end

	// rank table
	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
		rd_rank <= rank_mem[rd_addr];
	end

endmodule

`default_nettype wire

// ----- sv/kruskal_union_find_edge_filter.sv -----
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Spanning-forest edge filter: union by rank with path compression.
//
// Usage: edge words arrive on edge_valid/edge_stall in ascending weight order.
// cmd clear resets every node to its own root with rank zero and answers
// joined=0 with zero endpoints. A process word walks the parent chain of each
// endpoint to its root, one table read per cycle, then rewrites the same chain
// to point at the root, one node per cycle, and unites the two roots by rank.
// The walks and rewrites of both endpoints are serialized by the single read
// port of the parent table, and the next word is taken once the result is
// loaded into the output register. An edge with an endpoint not below
// NODE_COUNT is rejected and goes straight to the done state, whence its
// result is registered like any other. A clear, and the sweep after reset,
// writes one node per cycle with edge_stall high; a clear's result then
// passes through the done state to the output register.
// edge_stall stays high until the result is loaded into the output register.
// If result_stall holds a result, the next word is still taken, and its result
// waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_edge_filter #(
	parameter int NODE_COUNT = 1024
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                edge_valid,
	output logic               edge_stall,
	input  wire                cmd,
	input  kuf_pkg::node_t     first_node,
	input  kuf_pkg::node_t     second_node,
	output logic               result_valid,
	input  wire                result_stall,
	output logic               joined,
	output kuf_pkg::node_t     kept_first,
	output kuf_pkg::node_t     kept_second
);

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

	// sequencer states
	localparam logic [2:0] ST_CLR      = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_WALK_RD  = 3'd2;
	localparam logic [2:0] ST_WALK_CHK = 3'd3;
	localparam logic [2:0] ST_CMP_WR   = 3'd4;
	localparam logic [2:0] ST_UNION    = 3'd5;
	localparam logic [2:0] ST_DONE     = 3'd6;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             clr_q;
	logic             sel_q;
	kuf_pkg::node_t   a_q;
	kuf_pkg::node_t   b_q;
	logic [IDX_W-1:0] top_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] root_a_q;
	kuf_pkg::rank_t   rank_a_q;
	kuf_pkg::rank_t   rank_b_q;
	logic             joined_q;

	logic             result_valid_q;
	logic             joined_out_q;
	kuf_pkg::node_t   first_out_q;
	kuf_pkg::node_t   second_out_q;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] rd_parent;
	kuf_pkg::rank_t   rd_rank;
	logic             parent_we;
	logic [IDX_W-1:0] parent_waddr;
	logic [IDX_W-1:0] parent_wdata;
	logic             rank_we;
	logic [IDX_W-1:0] rank_waddr;
	kuf_pkg::rank_t   rank_wdata;

	logic             accept;
	logic             out_free;
	logic             in_range;
	logic             parent_is_top;
	logic             start_is_top;
	logic             roots_differ;
	logic             a_lower;
	logic             b_lower;

	assign accept     = edge_valid && !edge_stall;
	assign edge_stall = (state_q != ST_IDLE);
	assign out_free   = !result_valid_q || !result_stall;
	assign in_range   = (32'(first_node) < NODE_COUNT) && (32'(second_node) < NODE_COUNT);

	// shared compares against the current root and between the two root ranks
	assign parent_is_top = (rd_parent == top_q);
	assign start_is_top  = (start_q == top_q);
	assign roots_differ  = (root_a_q != top_q);
	assign a_lower       = (rank_a_q < rank_b_q);
	assign b_lower       = (rank_b_q < rank_a_q);

	kuf_forest_mem #(
		.DEPTH (NODE_COUNT),
		.IDX_W (IDX_W)
	) u_mem (
		.clk          (clk),
		.rd_addr      (rd_addr),
		.rd_parent    (rd_parent),
		.rd_rank      (rd_rank),
		.parent_we    (parent_we),
		.parent_waddr (parent_waddr),
		.parent_wdata (parent_wdata),
		.rank_we      (rank_we),
		.rank_waddr   (rank_waddr),
		.rank_wdata   (rank_wdata)
	);

	// table read address and write ports
	always_comb begin
		rd_addr      = top_q;
		parent_we    = 1'b0;
		parent_waddr = clr_cnt_q;
		parent_wdata = clr_cnt_q;
		rank_we      = 1'b0;
		rank_waddr   = clr_cnt_q;
		rank_wdata   = '0;
		case (state_q)
			ST_CLR: begin
				parent_we = 1'b1;
				rank_we   = 1'b1;
			end
			ST_WALK_CHK: begin
				if (!parent_is_top) begin
					rd_addr = rd_parent;
				end else begin
					rd_addr = start_q;
				end
			end
			ST_CMP_WR: begin
				parent_we    = 1'b1;
				parent_waddr = cur_q;
				parent_wdata = top_q;
				rd_addr      = rd_parent;
			end
			ST_UNION: begin
				if (roots_differ) begin
					parent_we = 1'b1;
					if (a_lower) begin
						parent_waddr = root_a_q;
						parent_wdata = top_q;
					end else begin
						parent_waddr = top_q;
						parent_wdata = root_a_q;
						if (!b_lower && rank_a_q != kuf_pkg::RANK_MAX) begin
							rank_we    = 1'b1;
							rank_waddr = root_a_q;
							rank_wdata = rank_a_q + kuf_pkg::rank_t'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cnt_q <= '0;
			clr_q     <= 1'b0;
			sel_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + IDX_W'(1);
					if (clr_cnt_q == LAST_IDX) begin
						state_q <= clr_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (cmd == kuf_pkg::CMD_CLEAR) begin
							clr_q     <= 1'b1;
							clr_cnt_q <= '0;
							state_q   <= ST_CLR;
						end else if (in_range) begin
							clr_q   <= 1'b0;
							sel_q   <= 1'b0;
							state_q <= ST_WALK_RD;
						end else begin
							clr_q   <= 1'b0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK_RD: begin
					state_q <= ST_WALK_CHK;
				end
				ST_WALK_CHK: begin
					if (parent_is_top) begin
						if (!start_is_top) begin
							state_q <= ST_CMP_WR;
						end else if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= ST_WALK_RD;
						end else begin
							state_q <= ST_UNION;
						end
					end
				end
				ST_CMP_WR: begin
					if (parent_is_top) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= ST_WALK_RD;
						end else begin
							state_q <= ST_UNION;
						end
					end
				end
				ST_UNION: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk and union datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					a_q      <= first_node;
					b_q      <= second_node;
					top_q    <= IDX_W'(first_node);
					start_q  <= IDX_W'(first_node);
					joined_q <= 1'b0;
				end
			end
			ST_WALK_CHK: begin
				if (!parent_is_top) begin
					top_q <= rd_parent;
				end else begin
					if (!sel_q) begin
						root_a_q <= top_q;
						rank_a_q <= rd_rank;
					end else begin
						rank_b_q <= rd_rank;
					end
					cur_q <= start_q;
					if (start_is_top && !sel_q) begin
						top_q   <= IDX_W'(b_q);
						start_q <= IDX_W'(b_q);
					end
				end
			end
			ST_CMP_WR: begin
				cur_q <= rd_parent;
				if (parent_is_top && !sel_q) begin
					top_q   <= IDX_W'(b_q);
					start_q <= IDX_W'(b_q);
				end
			end
			ST_UNION: begin
				joined_q <= roots_differ;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			joined_out_q <= joined_q && !clr_q;
			first_out_q  <= clr_q ? '0 : a_q;
			second_out_q <= clr_q ? '0 : b_q;
		end
	end

	assign result_valid = result_valid_q;
	assign joined       = joined_out_q;
	assign kept_first   = first_out_q;
	assign kept_second  = second_out_q;

endmodule

`default_nettype wire
